### rtl/core/mbb_pkg.sv
// Shared constants, codes and types for the monochrome bitmap blit framebuffer.
// No dependencies; every other file in rtl/core imports this package.
package mbb_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;

   // Framebuffer word: eight horizontal pixels, leftmost pixel in bit 7.
   localparam int WORDS_PER_ROW = (SCREEN_WIDTH + 7) / 8;
   localparam int FB_DEPTH      = WORDS_PER_ROW * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(FB_DEPTH);

   // Signed screen position width: 16-bit origin plus bitmap offset.
   localparam int POS_W = 18;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_CLEAR = 2'd0;
   localparam kind_type KIND_BYTE  = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_ORIGIN_X      = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y      = 3'd1;
   localparam csr_index_type CSR_BITMAP_WIDTH  = 3'd2;
   localparam csr_index_type CSR_BITMAP_HEIGHT = 3'd3;
   localparam csr_index_type CSR_INK_COLOR     = 3'd4;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [11:0]        bitmap_width;
      logic [11:0]        bitmap_height;
      logic [15:0]        ink_color;
   } cfg_type;

   // Placement of one bitmap byte onto two adjacent framebuffer words.
   typedef struct packed {
      logic [ADDR_W-1:0] addr_hi;
      logic [ADDR_W-1:0] addr_lo;
      logic [7:0]        mask_hi;
      logic [7:0]        mask_lo;
   } place_type;

endpackage

### rtl/core/mono_bitmap_blit_framebuffer.sv
// Top level of the monochrome bitmap blit framebuffer: sequencer around the frame RAM.
// Depends on mbb_pkg, mbb_csr_regs, mbb_draw_calc and mbb_frame_ram.
//
// One command word is taken at a time, when start is high and busy is low. A bitmap byte
// runs through accept, read, write/read and write (a read-modify-write of the two
// framebuffer words it can touch over the single read and write port). A cell read reads
// the top and then the bottom word; its result shows on rsp_strobe/rsp_cell_code for one
// cycle right after, and the receiver cannot stall it. A clear writes one word of zeros
// per cycle over all FB_DEPTH (1024) words. After reset the same pass runs with busy
// high; configuration writes are taken at any time and are meant for idle periods.
module mono_bitmap_blit_framebuffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mbb_pkg::kind_type      req_kind,
   input  logic [7:0]             req_bitmap_byte,
   input  logic [6:0]             req_cell_column,
   input  logic [4:0]             req_cell_row_pair,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_cell_code,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  mbb_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data
);
   import mbb_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_CLEAR      = 8'b0000_0010,
      S_DRAW_RD    = 8'b0000_0100,
      S_DRAW_WR_HI = 8'b0000_1000,
      S_DRAW_WR_LO = 8'b0001_0000,
      S_CELL_TOP   = 8'b0010_0000,
      S_CELL_BOT   = 8'b0100_0000,
      S_CELL_DONE  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   place_type         place_ff, place_in;
   place_type         place_calc;
   cfg_type           cfg;
   logic              geom_wr;
   logic              accept;
   logic              draw_step;

   logic [ADDR_W-1:0] cell_top_addr_ff, cell_top_addr_in;
   logic [ADDR_W-1:0] cell_bot_addr_ff, cell_bot_addr_in;
   logic [2:0]        cell_sel_ff, cell_sel_in;
   logic              cell_top_ok_ff, cell_top_ok_in;
   logic              cell_bot_ok_ff, cell_bot_ok_in;
   logic              top_px_ff, top_px_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]        rsp_code_ff, rsp_code_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign draw_step  = accept && (req_kind == KIND_BYTE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_cell_code = rsp_code_ff;

   mbb_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .geom_wr   (geom_wr)
   );

   mbb_draw_calc u_draw (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .geom_wr     (geom_wr),
      .step        (draw_step),
      .bitmap_byte (req_bitmap_byte),
      .place       (place_calc)
   );

   mbb_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic [31:0] top_row;
      top_row          = 32'({req_cell_row_pair, 1'b0});
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      place_in         = place_ff;
      cell_top_addr_in = cell_top_addr_ff;
      cell_bot_addr_in = cell_bot_addr_ff;
      cell_sel_in      = cell_sel_ff;
      cell_top_ok_in   = cell_top_ok_ff;
      cell_bot_ok_in   = cell_bot_ok_ff;
      top_px_in        = top_px_ff;
      rsp_strobe_in    = 1'b0;
      rsp_code_in      = rsp_code_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = place_ff.addr_hi;
      ram_wr_data      = ram_rd_data | place_ff.mask_hi;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = place_ff.addr_hi;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end
                  KIND_BYTE: begin
                     place_in = place_calc;
                     state_in = S_DRAW_RD;
                  end
                  KIND_READ: begin
                     cell_top_addr_in = ADDR_W'(top_row * WORDS_PER_ROW
                                               + 32'(req_cell_column >> 3));
                     cell_bot_addr_in = ADDR_W'((top_row + 32'd1) * WORDS_PER_ROW
                                               + 32'(req_cell_column >> 3));
                     cell_sel_in      = req_cell_column[2:0];
                     cell_top_ok_in   = (32'(req_cell_column) < SCREEN_WIDTH)
                                        && (top_row < SCREEN_HEIGHT);
                     cell_bot_ok_in   = (32'(req_cell_column) < SCREEN_WIDTH)
                                        && ((top_row + 32'd1) < SCREEN_HEIGHT);
                     state_in         = S_CELL_TOP;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 8'h00;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(FB_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_DRAW_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = place_ff.addr_hi;
            state_in    = S_DRAW_WR_HI;
         end
         S_DRAW_WR_HI: begin
            ram_wr_en   = |place_ff.mask_hi;
            ram_wr_addr = place_ff.addr_hi;
            ram_wr_data = ram_rd_data | place_ff.mask_hi;
            ram_rd_en   = 1'b1;
            ram_rd_addr = place_ff.addr_lo;
            state_in    = S_DRAW_WR_LO;
         end
         S_DRAW_WR_LO: begin
            ram_wr_en   = |place_ff.mask_lo;
            ram_wr_addr = place_ff.addr_lo;
            ram_wr_data = ram_rd_data | place_ff.mask_lo;
            state_in    = S_IDLE;
         end
         S_CELL_TOP: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cell_top_addr_ff;
            state_in    = S_CELL_BOT;
         end
         S_CELL_BOT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cell_bot_addr_ff;
            top_px_in   = cell_top_ok_ff && ram_rd_data[~cell_sel_ff];
            state_in    = S_CELL_DONE;
         end
         S_CELL_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_code_in   = {cell_bot_ok_ff && ram_rd_data[~cell_sel_ff], top_px_ff};
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      place_ff         <= place_in;
      cell_top_addr_ff <= cell_top_addr_in;
      cell_bot_addr_ff <= cell_bot_addr_in;
      cell_sel_ff      <= cell_sel_in;
      cell_top_ok_ff   <= cell_top_ok_in;
      cell_bot_ok_ff   <= cell_bot_ok_in;
      top_px_ff        <= top_px_in;
      rsp_code_ff      <= rsp_code_in;
   end

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_READ) |=> ##2 (state_ff == S_CELL_DONE) ##1 rsp_strobe)
      else $error("cell read did not produce a result word");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result word repeated");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_wr_en)
      else $error("framebuffer written while idle");

   a_clear_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_CLEAR) |=> (state_ff == S_CLEAR) && (clr_addr_ff == '0))
      else $error("clear word did not start the clearing pass");
`endif

endmodule

### rtl/core/mbb_csr_regs.sv
// Configuration registers of the bitmap blit framebuffer.
// Depends on mbb_pkg (register indexes, cfg_type).
module mbb_csr_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  mbb_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_data,
   output mbb_pkg::cfg_type      cfg,
   output logic                  geom_wr
);
   import mbb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      geom_wr = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X: begin
               cfg_in.origin_x = $signed(csr_data);
               geom_wr         = 1'b1;
            end
            CSR_ORIGIN_Y: begin
               cfg_in.origin_y = $signed(csr_data);
               geom_wr         = 1'b1;
            end
            CSR_BITMAP_WIDTH: begin
               cfg_in.bitmap_width = csr_data[11:0];
               geom_wr             = 1'b1;
            end
            CSR_BITMAP_HEIGHT: begin
               cfg_in.bitmap_height = csr_data[11:0];
               geom_wr              = 1'b1;
            end
            CSR_INK_COLOR: cfg_in.ink_color = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.bitmap_width  <= '0;
         cfg_ff.bitmap_height <= '0;
         cfg_ff.ink_color     <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/mbb_frame_ram.sv
// Framebuffer store: one write port, one read port, registered read data.
// Depends on mbb_pkg (FB_DEPTH, ADDR_W).
module mbb_frame_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [mbb_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic                      rd_en,
   input  logic [mbb_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);
   import mbb_pkg::*;

   logic [7:0] mem [FB_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mbb_draw_calc.sv
// Source row/byte counters and clipping/placement of one bitmap byte.
// Depends on mbb_pkg (cfg_type, place_type, screen constants).
module mbb_draw_calc (
   input  logic               clock,
   input  logic               reset,
   input  mbb_pkg::cfg_type   cfg,
   input  logic               geom_wr,
   input  logic               step,
   input  logic [7:0]         bitmap_byte,
   output mbb_pkg::place_type place
);
   import mbb_pkg::*;

   logic [11:0] row_ff, row_in;
   logic [8:0]  col_ff, col_in;

   always_comb begin
      logic signed [POS_W-1:0] dx0;
      logic signed [POS_W-1:0] dy;
      logic signed [POS_W-1:0] dx;
      logic signed [POS_W-1:0] w0;
      logic [12:0]             sx_base;
      logic [12:0]             sx;
      logic                    row_on;
      logic [7:0]              mask;
      logic [15:0]             win;
      logic [31:0]             base;
      dx0     = POS_W'(cfg.origin_x) + POS_W'({col_ff, 3'b000});
      dy      = POS_W'(cfg.origin_y) + POS_W'(row_ff);
      sx_base = {1'b0, col_ff, 3'b000};
      row_on  = (row_ff < cfg.bitmap_height) && (|cfg.ink_color) && !dy[POS_W-1]
                && (dy < POS_W'(SCREEN_HEIGHT));
      for (int b = 0; b < 8; b++) begin
         sx          = sx_base + 13'(b);
         dx          = dx0 + POS_W'(b);
         mask[7 - b] = bitmap_byte[7 - b] && row_on && (sx < {1'b0, cfg.bitmap_width})
                       && !dx[POS_W-1] && (dx < POS_W'(SCREEN_WIDTH));
      end
      win           = {mask, 8'h00} >> dx0[2:0];
      w0            = dx0 >>> 3;
      base          = 32'(dy) * WORDS_PER_ROW;
      place.addr_hi = ADDR_W'(base + 32'(w0));
      place.addr_lo = ADDR_W'(base + 32'(w0) + 32'd1);
      place.mask_hi = win[15:8];
      place.mask_lo = win[7:0];
   end

   always_comb begin
      logic [8:0]  col_nx;
      logic [11:0] row_nx;
      logic [9:0]  row_bytes;
      col_nx    = col_ff + 9'd1;
      row_nx    = row_ff + 12'd1;
      row_bytes = 10'((13'(cfg.bitmap_width) + 13'd7) >> 3);
      row_in    = row_ff;
      col_in    = col_ff;
      priority if (geom_wr) begin
         row_in = '0;
         col_in = '0;
      end else if (step && (cfg.bitmap_width != '0) && (cfg.bitmap_height != '0)) begin
         if ({1'b0, col_nx} >= row_bytes) begin
            col_in = '0;
            row_in = (row_nx >= cfg.bitmap_height) ? 12'd0 : row_nx;
         end else begin
            col_in = col_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule
